// ===== sv/rmrob_pkg.sv =====
// ----------------------------------------------------------------------------
// rmrob_pkg: shared types and constants
// Widths, command and status codes, and the queue entry for the rename/ROB.
// ----------------------------------------------------------------------------
package rmrob_pkg;

   localparam int ARCH_REGS  = 67;
   localparam int ROB_DEPTH  = 64;
   localparam int MAX_RETIRE = 8;
   localparam int TAG_W      = $clog2(ROB_DEPTH);
   localparam int REG_W      = $clog2(ARCH_REGS);
   localparam int RW_W       = $clog2(MAX_RETIRE + 1);
   localparam int CNT_W      = $clog2(ROB_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_RENAME   = 2'd0,
      CMD_COMPLETE = 2'd1,
      CMD_RETIRE   = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_STALL   = 2'd1,
      ST_NOTHING = 2'd2
   } status_type;

   // Back end sequencing: map read for a rename, and the three steps that
   // retire one head entry (read its destination, read that map tag, free it).
   typedef enum logic [2:0] {
      S_IDLE     = 3'd0,
      S_RENAME   = 3'd1,
      S_RET_DEST = 3'd2,
      S_RET_MAP  = 3'd3,
      S_RET_DO   = 3'd4
   } back_state_type;

   localparam logic [0:0] CSR_ROB_USED = 1'b0;
   localparam logic [0:0] CSR_RETIRE_W = 1'b1;

   // Classified request passed from the front end to the back end.
   typedef struct packed {
      cmd_type          cmd;
      logic             dest_ok;
      logic [REG_W-1:0] dest;
      logic             a_ok;
      logic [REG_W-1:0] a;
      logic             b_ok;
      logic [REG_W-1:0] b;
      logic [5:0]       done_slot;
   } op_type;

   // Check that a signed 8-bit register number names a real register.
   function automatic logic reg_ok(input logic signed [7:0] r);
      reg_ok = (r >= 8'sd0) && (r < 8'(ARCH_REGS));
   endfunction

endpackage

// ===== sv/rmrob_front.sv =====
// ----------------------------------------------------------------------------
// rmrob_front: request intake
// Accepts requests, classifies registers and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module rmrob_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         in_data,
   output logic                op_valid,
   input  logic                op_take,
   output rmrob_pkg::op_type   op
);
   rmrob_pkg::op_type op_new;
   rmrob_pkg::op_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;
   logic push, pop;
   logic signed [7:0] d, a, b;

   assign d = in_data[9:2];
   assign a = in_data[17:10];
   assign b = in_data[25:18];

   always_comb begin
      op_new.cmd       = rmrob_pkg::cmd_type'(in_data[1:0]);
      op_new.dest_ok   = rmrob_pkg::reg_ok(d);
      op_new.dest      = d[rmrob_pkg::REG_W-1:0];
      op_new.a_ok      = rmrob_pkg::reg_ok(a);
      op_new.a         = a[rmrob_pkg::REG_W-1:0];
      op_new.b_ok      = rmrob_pkg::reg_ok(b);
      op_new.b         = b[rmrob_pkg::REG_W-1:0];
      op_new.done_slot = in_data[31:26];
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign op_valid = (cnt_ff != 2'd0);
   assign pop      = op_valid && op_take;
   assign op       = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= op_new;
   end
endmodule

// ===== sv/rmrob_back.sv =====
// ----------------------------------------------------------------------------
// rmrob_back: rename map and reorder buffer engine
// Executes queued commands; each retired entry has its destination read, its map tag read, then its slot freed.
// ----------------------------------------------------------------------------
module rmrob_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [6:0]          rob_used,
   input  logic [3:0]          retire_w,
   input  logic                op_valid,
   output logic                op_take,
   input  rmrob_pkg::op_type   op,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [39:0]         out_data,
   output logic                out_last
);
   localparam int TW = rmrob_pkg::TAG_W;
   localparam int RW = rmrob_pkg::REG_W;

   rmrob_pkg::back_state_type state_ff, state_in;
   logic [rmrob_pkg::ARCH_REGS-1:0] map_valid_ff;
   logic [TW-1:0] map_tag_ff [rmrob_pkg::ARCH_REGS];
   logic [rmrob_pkg::ROB_DEPTH-1:0] busy_ff, ready_ff;
   logic [RW:0] dest_ff [rmrob_pkg::ROB_DEPTH];   // {ok, reg}
   logic [TW-1:0] head_ff, tail_ff;
   logic [rmrob_pkg::CNT_W-1:0] used_ff;
   logic [rmrob_pkg::RW_W-1:0] nret_ff;
   logic ov_ff, olast_ff;
   logic [39:0] od_ff;
   logic [TW-1:0] tag_a_ff, tag_b_ff;
   logic [RW:0] hd_ff;

   logic [rmrob_pkg::CNT_W-1:0] size;
   logic [rmrob_pkg::RW_W-1:0] width;
   logic free, full, load;
   logic [RW-1:0] rd_a;
   logic [TW-1:0] at, bt, hnext, tnext;
   logic ap, bp, h_ok, more;
   logic signed [7:0] rdest;
   logic do_stall, do_complete, do_nothing, do_rename, do_retire, start_ret;
   logic [39:0] od_in;
   logic olast_in;

   always_comb begin
      if (rob_used < 7'd2) size = rmrob_pkg::CNT_W'(2);
      else if (rob_used > 7'(rmrob_pkg::ROB_DEPTH))
         size = rmrob_pkg::CNT_W'(rmrob_pkg::ROB_DEPTH);
      else size = rmrob_pkg::CNT_W'(rob_used);
      if (retire_w < 4'd1) width = rmrob_pkg::RW_W'(1);
      else if (retire_w > 4'(rmrob_pkg::MAX_RETIRE))
         width = rmrob_pkg::RW_W'(rmrob_pkg::MAX_RETIRE);
      else width = rmrob_pkg::RW_W'(retire_w);
   end

   assign free = !ov_ff || out_ready;

   // The first map read port serves source A, or the retiring destination.
   assign rd_a = (state_ff == rmrob_pkg::S_RET_MAP || state_ff == rmrob_pkg::S_RET_DO) ?
                 hd_ff[RW-1:0] : op.a;

   always_comb begin
      ap = op.a_ok && map_valid_ff[op.a] && busy_ff[tag_a_ff] && !ready_ff[tag_a_ff];
      bp = op.b_ok && map_valid_ff[op.b] && busy_ff[tag_b_ff] && !ready_ff[tag_b_ff];
      at = ap ? tag_a_ff : '0;
      bt = bp ? tag_b_ff : '0;
      hnext = ((rmrob_pkg::CNT_W'(head_ff) + 1'b1) >= size) ? '0 : head_ff + 1'b1;
      tnext = ((rmrob_pkg::CNT_W'(tail_ff) + 1'b1) >= size) ? '0 : tail_ff + 1'b1;
      h_ok  = busy_ff[head_ff] && ready_ff[head_ff];
      rdest = hd_ff[RW] ? 8'(hd_ff[RW-1:0]) : -8'sd1;
      more  = (nret_ff + 1'b1 < width) && busy_ff[hnext] && ready_ff[hnext];
      full  = used_ff >= size;
   end

   // Next state and control strobes.
   always_comb begin
      state_in    = state_ff;
      op_take     = 1'b0;
      do_stall    = 1'b0;
      do_complete = 1'b0;
      do_nothing  = 1'b0;
      do_rename   = 1'b0;
      do_retire   = 1'b0;
      start_ret   = 1'b0;
      unique case (state_ff)
         rmrob_pkg::S_IDLE: begin
            if (op_valid) begin
               unique case (op.cmd)
                  rmrob_pkg::CMD_RENAME: begin
                     if (!full) state_in = rmrob_pkg::S_RENAME;
                     else if (free) begin
                        do_stall = 1'b1;
                        op_take  = 1'b1;
                     end
                  end
                  rmrob_pkg::CMD_COMPLETE: begin
                     if (free) begin
                        do_complete = 1'b1;
                        op_take     = 1'b1;
                     end
                  end
                  rmrob_pkg::CMD_RETIRE: begin
                     if (h_ok) begin
                        start_ret = 1'b1;
                        op_take   = 1'b1;
                        state_in  = rmrob_pkg::S_RET_DEST;
                     end else if (free) begin
                        do_nothing = 1'b1;
                        op_take    = 1'b1;
                     end
                  end
                  default: op_take = 1'b1;
               endcase
            end
         end
         rmrob_pkg::S_RENAME: begin
            if (free) begin
               do_rename = 1'b1;
               op_take   = 1'b1;
               state_in  = rmrob_pkg::S_IDLE;
            end
         end
         rmrob_pkg::S_RET_DEST: state_in = rmrob_pkg::S_RET_MAP;
         rmrob_pkg::S_RET_MAP:  state_in = rmrob_pkg::S_RET_DO;
         rmrob_pkg::S_RET_DO: begin
            if (free) begin
               do_retire = 1'b1;
               state_in  = more ? rmrob_pkg::S_RET_DEST : rmrob_pkg::S_IDLE;
            end
         end
         default: state_in = rmrob_pkg::S_IDLE;
      endcase
   end

   // out_data: status[1:0] slot_tag[7:2] a_tag[13:8] a_pend[14] b_tag[20:15]
   // b_pend[21] retired_dest[29:22]
   always_comb begin
      od_in    = {10'd0, -8'sd1, 20'd0, rmrob_pkg::ST_DONE};
      olast_in = 1'b1;
      if (do_stall) od_in = {10'd0, -8'sd1, 20'd0, rmrob_pkg::ST_STALL};
      else if (do_nothing) od_in = {10'd0, -8'sd1, 20'd0, rmrob_pkg::ST_NOTHING};
      else if (do_complete)
         od_in = {10'd0, -8'sd1, 14'd0, op.done_slot, rmrob_pkg::ST_DONE};
      else if (do_rename)
         od_in = {10'd0, -8'sd1, bp, bt, ap, at, tail_ff, rmrob_pkg::ST_DONE};
      else if (do_retire) begin
         od_in    = {10'd0, rdest, 14'd0, head_ff, rmrob_pkg::ST_DONE};
         olast_in = !more;
      end
   end

   assign load = do_stall || do_nothing || do_complete || do_rename || do_retire;

   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign out_last  = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rmrob_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   // Map tags and slot destinations are memories with registered reads.
   always_ff @(posedge clock) begin
      tag_a_ff <= map_tag_ff[rd_a];
      tag_b_ff <= map_tag_ff[op.b];
      hd_ff    <= dest_ff[head_ff];
      if (do_rename) begin
         dest_ff[tail_ff] <= {op.dest_ok, op.dest_ok ? op.dest : RW'(0)};
         if (op.dest_ok) map_tag_ff[op.dest] <= tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         busy_ff      <= '0;
         ready_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         nret_ff      <= '0;
         ov_ff        <= 1'b0;
      end else begin
         ov_ff <= load || (ov_ff && !out_ready);
         if (load) begin
            od_ff    <= od_in;
            olast_ff <= olast_in;
         end
         if (start_ret) nret_ff <= '0;
         if (do_complete && rmrob_pkg::CNT_W'(op.done_slot) < size && busy_ff[op.done_slot])
            ready_ff[op.done_slot] <= 1'b1;
         if (do_rename) begin
            busy_ff[tail_ff]  <= 1'b1;
            ready_ff[tail_ff] <= 1'b0;
            if (op.dest_ok) map_valid_ff[op.dest] <= 1'b1;
            tail_ff <= tnext;
            used_ff <= used_ff + 1'b1;
         end
         if (do_retire) begin
            if (hd_ff[RW] && map_valid_ff[hd_ff[RW-1:0]] && tag_a_ff == head_ff)
               map_valid_ff[hd_ff[RW-1:0]] <= 1'b0;
            busy_ff[head_ff]  <= 1'b0;
            ready_ff[head_ff] <= 1'b0;
            head_ff <= hnext;
            if (used_ff != '0) used_ff <= used_ff - 1'b1;
            nret_ff <= nret_ff + 1'b1;
         end
      end
   end
endmodule

// ===== sv/rename_map_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// rename_map_reorder_buffer: register rename map with a reorder buffer
// A front end queues requests; a back end renames, completes and retires.
// ----------------------------------------------------------------------------
// Responses: a complete, a stalled rename or an empty retire is answered from the
// idle state; a rename first reads the map and holds the back end until done.
// A retire answers once per retired entry, each time after reading the
// destination, reading the map tag and freeing the slot.
// Throughput: one complete per cycle unless rsp_tready stalls it.
// Reset: synchronous; clears the map valid bits, ROB busy/ready and pointers.
module rename_map_reorder_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: cmd[1:0] dest_reg[9:2] src_a_reg[17:10] src_b_reg[25:18]
   // done_slot[31:26]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0] slot_tag[7:2] src_a_tag[13:8] src_a_pending[14]
   // src_b_tag[20:15] src_b_pending[21] retired_dest[29:22]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);
   logic [6:0] rob_used_ff;
   logic [3:0] retire_w_ff;
   logic op_valid, op_take;
   rmrob_pkg::op_type op;

   // Configuration registers are used directly by the back end, also mid-command.
   always_ff @(posedge clock) begin
      if (reset) begin
         rob_used_ff <= 7'd64;
         retire_w_ff <= 4'd1;
      end else if (csr_we) begin
         if (csr_index == rmrob_pkg::CSR_ROB_USED) rob_used_ff <= csr_wdata;
         else retire_w_ff <= csr_wdata[3:0];
      end
   end

   rmrob_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .op_valid, .op_take, .op
   );

   rmrob_back u_back (
      .clock, .reset,
      .rob_used(rob_used_ff), .retire_w(retire_w_ff),
      .op_valid, .op_take, .op,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_data(rsp_tdata), .out_last(rsp_tlast)
   );
endmodule
